// ----- rtl/tjp_pkg.sv -----
// tjp_pkg: types, constants and the arctangent table for target_to_joint_pulses_core.
// Shared by every module in rtl/. No dependencies.
`timescale 1ns / 1ps

package tjp_pkg;

    localparam int MAX_STAGES    = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int NSTG          = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int SW            = $clog2(MAX_STAGES);

    // CORDIC datapath: inputs scaled by 2^20, plus growth
    localparam int CW    = 40;
    localparam int XY_SH = 20;
    // angle accumulator, signed Q.16 degrees
    localparam int AW    = 27;
    localparam int RMW   = AW - 1;
    localparam int LDW   = 34;
    localparam int LMW   = 32;
    localparam int RPW   = RMW + 32;
    localparam int LPW   = LMW + 32;
    localparam int QW    = LPW - 16 + 1;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic [SW-1:0]        stg_t;

    localparam ang_t DEG180 = ang_t'(11796480);
    localparam ang_t DEG90  = ang_t'(5898240);

    localparam ang_t               ROTARY_ZERO = ang_t'(0);
    localparam logic signed [31:0] LINEAR_ZERO = 32'sd0;

    typedef enum logic [2:0] {
        REG_X_MIN       = 3'd0,
        REG_X_MAX       = 3'd1,
        REG_Y_MIN       = 3'd2,
        REG_Y_MAX       = 3'd3,
        REG_Z_MIN       = 3'd4,
        REG_Z_MAX       = 3'd5,
        REG_ANGLE_SCALE = 3'd6,
        REG_DEPTH_SCALE = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
    } target_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] rotary_pulses;
        logic signed [31:0] linear_pulses;
    } pulses_t;

    typedef struct packed {
        cw_t                x;
        cw_t                y;
        ang_t               z;
        logic signed [15:0] depth;
        logic               origin;
        logic               outside;
    } cordic_t;

    // atan(2^-i) in Q.16 degrees, rounded to nearest
    function automatic ang_t atan_q16(input stg_t idx);
        case (idx)
            5'd0:    atan_q16 = ang_t'(2949120);
            5'd1:    atan_q16 = ang_t'(1740967);
            5'd2:    atan_q16 = ang_t'(919879);
            5'd3:    atan_q16 = ang_t'(466945);
            5'd4:    atan_q16 = ang_t'(234379);
            5'd5:    atan_q16 = ang_t'(117304);
            5'd6:    atan_q16 = ang_t'(58666);
            5'd7:    atan_q16 = ang_t'(29335);
            5'd8:    atan_q16 = ang_t'(14668);
            5'd9:    atan_q16 = ang_t'(7334);
            5'd10:   atan_q16 = ang_t'(3667);
            5'd11:   atan_q16 = ang_t'(1833);
            5'd12:   atan_q16 = ang_t'(917);
            5'd13:   atan_q16 = ang_t'(458);
            5'd14:   atan_q16 = ang_t'(229);
            5'd15:   atan_q16 = ang_t'(115);
            5'd16:   atan_q16 = ang_t'(57);
            5'd17:   atan_q16 = ang_t'(29);
            5'd18:   atan_q16 = ang_t'(14);
            5'd19:   atan_q16 = ang_t'(7);
            5'd20:   atan_q16 = ang_t'(4);
            5'd21:   atan_q16 = ang_t'(2);
            5'd22:   atan_q16 = ang_t'(1);
            default: atan_q16 = '0;
        endcase
    endfunction

endpackage

// ----- rtl/tjp_front.sv -----
// tjp_front: workspace limit check and quadrant pre-rotation, first pipeline stage.
// Depends on tjp_pkg.
`timescale 1ns / 1ps

module tjp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tjp_pkg::target_t   in_data,
    output logic               adv,
    input  logic signed [15:0] x_min,
    input  logic signed [15:0] x_max,
    input  logic signed [15:0] y_min,
    input  logic signed [15:0] y_max,
    input  logic signed [15:0] z_min,
    input  logic signed [15:0] z_max,
    input  logic               adv_out,
    output logic               out_valid,
    output tjp_pkg::cordic_t   out_data
);
    import tjp_pkg::*;

    logic               valid_reg;
    cordic_t            data_reg;
    cordic_t            data_next;
    logic signed [16:0] x17;
    logic signed [16:0] y17;
    logic signed [16:0] rx;
    logic signed [16:0] ry;

    assign adv = !valid_reg || adv_out;

    always_comb
    begin
        x17 = 17'(in_data.target_x);
        y17 = 17'(in_data.target_y);
        data_next         = '0;
        data_next.depth   = in_data.target_z;
        data_next.origin  = (in_data.target_x == '0) && (in_data.target_y == '0);
        data_next.outside = (in_data.target_x < x_min) || (in_data.target_x > x_max)
                         || (in_data.target_y < y_min) || (in_data.target_y > y_max)
                         || (in_data.target_z < z_min) || (in_data.target_z > z_max);
        if (x17[16])
        begin
            if (!y17[16])
            begin
                rx          = y17;
                ry          = -x17;
                data_next.z = DEG90;
            end
            else
            begin
                rx          = -y17;
                ry          = x17;
                data_next.z = -DEG90;
            end
        end
        else
        begin
            rx = x17;
            ry = y17;
        end
        data_next.x = {{(CW - 17 - XY_SH){rx[16]}}, rx, {XY_SH{1'b0}}};
        data_next.y = {{(CW - 17 - XY_SH){ry[16]}}, ry, {XY_SH{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/tjp_cell.sv -----
// tjp_cell: one CORDIC vectoring iteration with its pipeline register.
// Depends on tjp_pkg; shift and arctangent step are tied off by the parent.
`timescale 1ns / 1ps

module tjp_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  tjp_pkg::stg_t    shift,
    input  tjp_pkg::ang_t    atan_step,
    input  logic             in_valid,
    input  tjp_pkg::cordic_t in_data,
    output logic             adv,
    input  logic             adv_out,
    output logic             out_valid,
    output tjp_pkg::cordic_t out_data
);
    import tjp_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    cw_t     xs;
    cw_t     ys;

    assign adv = !valid_reg || adv_out;

    always_comb
    begin
        xs        = in_data.x >>> shift;
        ys        = in_data.y >>> shift;
        data_next = in_data;
        if (!in_data.y[CW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + atan_step;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/tjp_scale.sv -----
// tjp_scale: angle clamp, zero offsets, pulse scaling, rounding, saturation, output register.
// Depends on tjp_pkg. Three stages: magnitude, multiply, round/saturate.
`timescale 1ns / 1ps

module tjp_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tjp_pkg::cordic_t in_data,
    output logic             adv,
    input  logic [31:0]      angle_scale,
    input  logic [31:0]      depth_scale,
    output logic             out_valid,
    output tjp_pkg::pulses_t out_data,
    input  logic             out_stall
);
    import tjp_pkg::*;

    logic en1;
    logic en2;
    logic en3;

    // stage 1
    logic                  v1_reg;
    logic                  out1_reg;
    logic                  rneg1_reg;
    logic [RMW-1:0]        rmag1_reg;
    logic                  lneg1_reg;
    logic [LMW-1:0]        lmag1_reg;
    ang_t                  ang;
    ang_t                  rdiff;
    logic signed [LDW-1:0] ldiff;
    ang_t                  rabs;
    logic signed [LDW-1:0] labs;

    // stage 2
    logic                  v2_reg;
    logic                  out2_reg;
    logic                  rneg2_reg;
    logic                  lneg2_reg;
    logic [RPW-1:0]        rprod_reg;
    logic [LPW-1:0]        lprod_reg;
    logic [RPW-1:0]        rprod_next;
    logic [LPW-1:0]        lprod_next;

    // stage 3
    logic                  v3_reg;
    pulses_t               res_reg;
    pulses_t               res_next;
    logic [RPW-1:0]        rsum;
    logic [LPW:0]          lsum;
    logic [QW-1:0]         rq;
    logic [QW-1:0]         lq;

    function automatic logic signed [31:0] sat32(input logic neg, input logic [QW-1:0] q);
        if (neg)
            sat32 = (q >= QW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
        else
            sat32 = (q >= QW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign adv = en1;

    always_comb
    begin
        if (in_data.origin)
            ang = '0;
        else if (in_data.z > DEG180)
            ang = DEG180;
        else if (in_data.z < -DEG180)
            ang = -DEG180;
        else
            ang = in_data.z;
        rdiff = ang - ROTARY_ZERO;
        ldiff = LDW'(in_data.depth) - LDW'(LINEAR_ZERO);
        rabs  = rdiff[AW-1] ? -rdiff : rdiff;
        labs  = ldiff[LDW-1] ? -ldiff : ldiff;
    end

    always_comb
    begin
        rprod_next = RPW'(rmag1_reg) * RPW'(angle_scale);
        lprod_next = LPW'(lmag1_reg) * LPW'(depth_scale);
    end

    always_comb
    begin
        rsum = rprod_reg + RPW'(64'h8000_0000);
        lsum = {1'b0, lprod_reg} + (LPW + 1)'(17'h8000);
        rq   = QW'(rsum[RPW-1:32]);
        lq   = lsum[LPW:16];
        res_next = '0;
        if (out2_reg)
            res_next.status = 1'b1;
        else
        begin
            res_next.rotary_pulses = sat32(rneg2_reg, rq);
            res_next.linear_pulses = sat32(lneg2_reg, lq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            out1_reg  <= in_data.outside;
            rneg1_reg <= rdiff[AW-1];
            rmag1_reg <= rabs[RMW-1:0];
            lneg1_reg <= ldiff[LDW-1];
            lmag1_reg <= labs[LMW-1:0];
        end
        if (en2 && v1_reg)
        begin
            out2_reg  <= out1_reg;
            rneg2_reg <= rneg1_reg;
            lneg2_reg <= lneg1_reg;
            rprod_reg <= rprod_next;
            lprod_reg <= lprod_next;
        end
        if (en3 && v2_reg)
            res_reg <= res_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = res_reg;

endmodule

// ----- rtl/target_to_joint_pulses_core.sv -----
// Throughput is one target per clock while pulses_stall is low: every stage of the pipeline holds
// its own beat and moves up when the stage after it is empty or moving, so bubbles collapse and a
// stalled result does not stop the stages behind it from filling. The pipeline is one limit-check
// stage, one register per CORDIC cell (NSTG of them, 16 CORDIC stages), then magnitude, multiply
// and round/saturate stages, the last of which is the output register.
// target_to_joint_pulses_core: top level, configuration registers, CORDIC cell chain.
// Depends on tjp_pkg, tjp_front, tjp_cell, tjp_scale.
`timescale 1ns / 1ps

module target_to_joint_pulses_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             target_valid,
    output logic             target_stall,
    input  tjp_pkg::target_t target,
    output logic             pulses_valid,
    input  logic             pulses_stall,
    output tjp_pkg::pulses_t pulses,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import tjp_pkg::*;

    logic signed [15:0] x_min_reg;
    logic signed [15:0] x_max_reg;
    logic signed [15:0] y_min_reg;
    logic signed [15:0] y_max_reg;
    logic signed [15:0] z_min_reg;
    logic signed [15:0] z_max_reg;
    logic [31:0]        angle_scale_reg;
    logic [31:0]        depth_scale_reg;

    logic    fr_adv;
    logic    ch_valid [NSTG+1];
    cordic_t ch_data  [NSTG+1];
    logic    ch_adv   [NSTG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg       <= -16'sd32768;
            x_max_reg       <= 16'sd32767;
            y_min_reg       <= -16'sd32768;
            y_max_reg       <= 16'sd32767;
            z_min_reg       <= -16'sd32768;
            z_max_reg       <= 16'sd32767;
            angle_scale_reg <= 32'd65536;
            depth_scale_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_X_MIN:       x_min_reg       <= cfg_data[15:0];
                REG_X_MAX:       x_max_reg       <= cfg_data[15:0];
                REG_Y_MIN:       y_min_reg       <= cfg_data[15:0];
                REG_Y_MAX:       y_max_reg       <= cfg_data[15:0];
                REG_Z_MIN:       z_min_reg       <= cfg_data[15:0];
                REG_Z_MAX:       z_max_reg       <= cfg_data[15:0];
                REG_ANGLE_SCALE: angle_scale_reg <= cfg_data;
                REG_DEPTH_SCALE: depth_scale_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    tjp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (target_valid),
        .in_data   (target),
        .adv       (fr_adv),
        .x_min     (x_min_reg),
        .x_max     (x_max_reg),
        .y_min     (y_min_reg),
        .y_max     (y_max_reg),
        .z_min     (z_min_reg),
        .z_max     (z_max_reg),
        .adv_out   (ch_adv[0]),
        .out_valid (ch_valid[0]),
        .out_data  (ch_data[0])
    );

    assign target_stall = !fr_adv;

    for (genvar i = 0; i < NSTG; i++)
    begin : g_cell
        tjp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (stg_t'(i)),
            .atan_step (atan_q16(stg_t'(i))),
            .in_valid  (ch_valid[i]),
            .in_data   (ch_data[i]),
            .adv       (ch_adv[i]),
            .adv_out   (ch_adv[i+1]),
            .out_valid (ch_valid[i+1]),
            .out_data  (ch_data[i+1])
        );
    end

    tjp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (ch_valid[NSTG]),
        .in_data     (ch_data[NSTG]),
        .adv         (ch_adv[NSTG]),
        .angle_scale (angle_scale_reg),
        .depth_scale (depth_scale_reg),
        .out_valid   (pulses_valid),
        .out_data    (pulses),
        .out_stall   (pulses_stall)
    );

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pulses_valid && pulses.status |-> pulses.rotary_pulses == '0 && pulses.linear_pulses == '0)
        else $error("outside-workspace beat carries nonzero pulses");

    a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
        !ch_valid[0] |-> !target_stall)
        else $error("input stalled while first stage is empty");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !pulses_valid |-> ch_adv[NSTG])
        else $error("last cell blocked while output register is empty");

endmodule
